/* hdl/weighted_rectangle_sum_tables_unit_defines.svh */
// Assertion macros for the checker module of the block.
`ifndef WEIGHTED_RECTANGLE_SUM_TABLES_UNIT_DEFINES_SVH
`define WEIGHTED_RECTANGLE_SUM_TABLES_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WRST_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WRST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/wrst_pkg.sv */
package wrst_pkg;

    localparam int CORNER_W   = 8;
    localparam int VALUE_IN_W = 16;
    localparam int SUM_W      = 48;
    localparam int GRID_W     = 9;
    localparam int WIDTH_W    = CORNER_W + 1;
    localparam int BASE_W     = 2 * CORNER_W + 1;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int CFG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [GRID_W-1:0]    GRID_SIZE_RESET   = 9'd256;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_GRID_SIZE = 1'b0;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic                  action;
        logic [VALUE_IN_W-1:0] cell_value;
        logic [CORNER_W-1:0]   top_row;
        logic [CORNER_W-1:0]   left_col;
        logic [CORNER_W-1:0]   bottom_row;
        logic [CORNER_W-1:0]   right_col;
    } t_in_item;

    typedef struct packed {
        logic [SUM_W-1:0] weighted_sum;
        logic             bad_query;
    } t_out_item;

endpackage

/* hdl/weighted_rectangle_sum_tables_unit.sv */
// Weighted rectangle sums over a square grid held in one table memory.
// Input channel (i_in_valid/o_in_ready/i_in_data) carries one transaction per
// item: a load of the next grid cell in raster order, or a rectangle query.
// Output channel (o_out_valid/i_out_ready/o_out_data) carries one transaction
// per query; loads produce nothing.
// The grid side is set through the APB register at byte address 0 and writing
// it restarts loading. Write it only while the block is idle.
// One item is worked on at a time; o_in_ready is low from acceptance until the
// block is idle again. A load makes one memory read of the cell above, then one
// write; a load that arrives with the grid full is dropped. A valid query makes
// four corner reads through the single read port of the table memory, then has
// one multiply stage and one output stage. A rejected query goes from its first
// read state straight to the output stage. The result sits in an output register.
// When the receiver stalls, the register holds the result and the block goes on
// taking items; a following query waits in its output stage until it is taken.
// Reset clears the load position, the row sums and the output valid, and sets
// the grid side to 256. The table memory is not cleared; every entry a valid
// query reads has been written while the grid was loaded.
module weighted_rectangle_sum_tables_unit
    import wrst_pkg::*;
#(
    parameter int MAX_SIDE   = 256,
    parameter int VALUE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    output logic [APB_DATA_W-1:0] o_prdata,
    output logic                  o_pready
);

    localparam int CLW     = $clog2(MAX_SIDE);
    localparam int RW      = $clog2(MAX_SIDE + 1);
    localparam int CELLS   = MAX_SIDE * MAX_SIDE;
    localparam int AW      = $clog2(CELLS);
    localparam int EVB     = (VALUE_BITS < VALUE_IN_W) ? VALUE_BITS : VALUE_IN_W;
    localparam int PW_FULL = EVB + 2 * CLW;
    localparam int WW_FULL = EVB + 3 * CLW;
    localparam int PW      = (PW_FULL < SUM_W) ? PW_FULL : SUM_W;
    localparam int WW      = (WW_FULL < SUM_W) ? WW_FULL : SUM_W;
    localparam int MW      = PW + 2 * WW;
    localparam int GW      = (RW > GRID_W) ? RW : GRID_W;
    localparam int QW      = (RW > CORNER_W) ? RW : CORNER_W;
    localparam int P2W     = WW + WIDTH_W;
    localparam int P1W     = PW + BASE_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LD_RD = 4'd1;
    localparam logic [3:0] S_LD_WR = 4'd2;
    localparam logic [3:0] S_Q_A   = 4'd3;
    localparam logic [3:0] S_Q_B   = 4'd4;
    localparam logic [3:0] S_Q_C   = 4'd5;
    localparam logic [3:0] S_Q_D   = 4'd6;
    localparam logic [3:0] S_Q_E   = 4'd7;
    localparam logic [3:0] S_Q_MUL = 4'd8;
    localparam logic [3:0] S_Q_OUT = 4'd9;

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] row,
                                                input logic [CLW-1:0] col);
        cell_addr = AW'(row) * AW'(MAX_SIDE) + AW'(col);
    endfunction

    logic [3:0]        r_state;
    logic [3:0]        n_state;
    logic [GRID_W-1:0] r_grid_size;
    logic [RW-1:0]     r_load_row;
    logic [CLW-1:0]    r_load_col;
    logic [PW-1:0]     r_rs0;
    logic [WW-1:0]     r_rs1;
    logic [WW-1:0]     r_rs2;
    logic [PW-1:0]     n_rs0;
    logic [WW-1:0]     n_rs1;
    logic [WW-1:0]     n_rs2;
    t_in_item          r_item;
    logic [WW-1:0]     r_prod_r;
    logic [WW-1:0]     r_prod_c;
    logic              r_bad;
    logic [WIDTH_W-1:0] r_width;
    logic [BASE_W-1:0] r_bprod;
    logic [BASE_W-1:0] r_base;
    logic [PW-1:0]     r_acc0;
    logic [WW-1:0]     r_acc1;
    logic [WW-1:0]     r_acc2;
    logic [SUM_W-1:0]  r_t1;
    logic [SUM_W-1:0]  r_t2;
    logic              r_out_valid;
    t_out_item         r_out;

    logic [MW-1:0]     r_mem [CELLS];
    logic [MW-1:0]     r_rd_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [MW-1:0]     wr_data;

    logic [GW-1:0]     grid_ext;
    logic [GW-1:0]     side_ext;
    logic [RW-1:0]     side_n;
    logic              in_acc;
    logic              cfg_wr;
    logic              out_free;
    logic              load_full;
    logic              last_col;
    logic [EVB-1:0]    cell_v;
    logic [CORNER_W-1:0] r1m;
    logic [CORNER_W-1:0] c1m;
    logic              r1_nz;
    logic              c1_nz;
    logic              q_bad;
    logic [PW-1:0]     rd_plain;
    logic [WW-1:0]     rd_roww;
    logic [WW-1:0]     rd_colw;
    logic [P2W-1:0]    p2;
    logic [P1W-1:0]    p1;

    assign in_acc   = i_in_valid && o_in_ready;
    assign cfg_wr   = i_psel && i_penable && i_pwrite && o_pready
                      && (i_paddr[APB_ADDR_W-1:2] == CFG_IDX_GRID_SIZE);
    assign out_free = !r_out_valid || i_out_ready;

    assign grid_ext = GW'(r_grid_size);
    assign side_ext = (grid_ext == '0) ? GW'(1)
                    : (grid_ext > GW'(MAX_SIDE)) ? GW'(MAX_SIDE) : grid_ext;
    assign side_n   = side_ext[RW-1:0];

    assign load_full = (r_load_row >= side_n);
    assign last_col  = ((RW'(r_load_col) + RW'(1)) >= side_n);
    assign cell_v    = r_item.cell_value[EVB-1:0];

    assign r1_nz = (r_item.top_row != '0);
    assign c1_nz = (r_item.left_col != '0);
    assign r1m   = r1_nz ? r_item.top_row - CORNER_W'(1) : r_item.top_row;
    assign c1m   = c1_nz ? r_item.left_col - CORNER_W'(1) : r_item.left_col;
    assign q_bad = !load_full
                || (r_item.top_row > r_item.bottom_row)
                || (r_item.left_col > r_item.right_col)
                || (QW'(r_item.bottom_row) >= QW'(side_n))
                || (QW'(r_item.right_col) >= QW'(side_n));

    assign rd_plain = r_rd_data[PW-1:0];
    assign rd_roww  = r_rd_data[PW+WW-1:PW];
    assign rd_colw  = r_rd_data[MW-1:PW+WW];

    assign n_rs0 = r_rs0 + PW'(cell_v);
    assign n_rs1 = r_rs1 + r_prod_r;
    assign n_rs2 = r_rs2 + r_prod_c;

    assign wr_en   = (r_state == S_LD_WR);
    assign wr_addr = cell_addr(r_load_row, r_load_col);
    assign wr_data = (r_load_row != '0)
                   ? {rd_colw + n_rs2, rd_roww + n_rs1, rd_plain + n_rs0}
                   : {n_rs2, n_rs1, n_rs0};

    assign p2 = P2W'(r_acc1) * P2W'(r_width);
    assign p1 = P1W'(r_acc0) * P1W'(r_base);

    always_comb begin
        n_state = r_state;
        rd_en   = 1'b0;
        rd_addr = '0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_in_data.action == ACT_QUERY) ? S_Q_A : S_LD_RD;
                end
            end
            S_LD_RD: begin
                if (load_full) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_LD_WR;
                    rd_en   = 1'b1;
                    rd_addr = cell_addr((r_load_row != '0) ? r_load_row - RW'(1)
                                                           : r_load_row,
                                        r_load_col);
                end
            end
            S_LD_WR: begin
                n_state = S_IDLE;
            end
            S_Q_A: begin
                n_state = q_bad ? S_Q_OUT : S_Q_B;
                rd_en   = 1'b1;
                rd_addr = cell_addr(RW'(r_item.bottom_row), CLW'(r_item.right_col));
            end
            S_Q_B: begin
                n_state = S_Q_C;
                rd_en   = 1'b1;
                rd_addr = cell_addr(RW'(r1m), CLW'(r_item.right_col));
            end
            S_Q_C: begin
                n_state = S_Q_D;
                rd_en   = 1'b1;
                rd_addr = cell_addr(RW'(r_item.bottom_row), CLW'(c1m));
            end
            S_Q_D: begin
                n_state = S_Q_E;
                rd_en   = 1'b1;
                rd_addr = cell_addr(RW'(r1m), CLW'(c1m));
            end
            S_Q_E: begin
                n_state = S_Q_MUL;
            end
            S_Q_MUL: begin
                n_state = S_Q_OUT;
            end
            S_Q_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_grid_size <= GRID_SIZE_RESET;
            r_load_row  <= '0;
            r_load_col  <= '0;
            r_rs0       <= '0;
            r_rs1       <= '0;
            r_rs2       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                r_grid_size <= i_pwdata[GRID_W-1:0];
                r_load_row  <= '0;
                r_load_col  <= '0;
                r_rs0       <= '0;
                r_rs1       <= '0;
                r_rs2       <= '0;
            end else if (r_state == S_LD_WR) begin
                if (last_col) begin
                    r_load_col <= '0;
                    r_load_row <= r_load_row + RW'(1);
                    r_rs0      <= '0;
                    r_rs1      <= '0;
                    r_rs2      <= '0;
                end else begin
                    r_load_col <= r_load_col + CLW'(1);
                    r_rs0      <= n_rs0;
                    r_rs1      <= n_rs1;
                    r_rs2      <= n_rs2;
                end
            end
            if ((r_state == S_Q_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= i_in_data;
        end
        case (r_state)
            S_LD_RD: begin
                r_prod_r <= WW'(cell_v) * WW'(r_load_row);
                r_prod_c <= WW'(cell_v) * WW'(r_load_col);
            end
            S_Q_A: begin
                r_bad   <= q_bad;
                r_width <= WIDTH_W'(r_item.right_col) - WIDTH_W'(r_item.left_col)
                           + WIDTH_W'(1);
            end
            S_Q_B: begin
                r_acc0  <= rd_plain;
                r_acc1  <= rd_roww;
                r_acc2  <= rd_colw;
                r_bprod <= BASE_W'(r_width) * BASE_W'(r_item.top_row);
            end
            S_Q_C: begin
                if (r1_nz) begin
                    r_acc0 <= r_acc0 - rd_plain;
                    r_acc1 <= r_acc1 - rd_roww;
                    r_acc2 <= r_acc2 - rd_colw;
                end
                r_base <= r_bprod + BASE_W'(r_item.left_col) - BASE_W'(1);
            end
            S_Q_D: begin
                if (c1_nz) begin
                    r_acc0 <= r_acc0 - rd_plain;
                    r_acc1 <= r_acc1 - rd_roww;
                    r_acc2 <= r_acc2 - rd_colw;
                end
            end
            S_Q_E: begin
                if (r1_nz && c1_nz) begin
                    r_acc0 <= r_acc0 + rd_plain;
                    r_acc1 <= r_acc1 + rd_roww;
                    r_acc2 <= r_acc2 + rd_colw;
                end
            end
            S_Q_MUL: begin
                r_t2 <= SUM_W'(p2);
                // The base offset is minus one when the rectangle starts at the origin.
                r_t1 <= (!r1_nz && !c1_nz) ? SUM_W'(0) - SUM_W'(r_acc0) : SUM_W'(p1);
            end
            S_Q_OUT: begin
                if (out_free) begin
                    if (r_bad) begin
                        r_out.weighted_sum <= '0;
                        r_out.bad_query    <= 1'b1;
                    end else begin
                        r_out.weighted_sum <= SUM_W'(r_acc2) + r_t2 - r_t1;
                        r_out.bad_query    <= 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_pready    = 1'b1;
    assign o_prdata    = (i_paddr[APB_ADDR_W-1:2] == CFG_IDX_GRID_SIZE)
                       ? APB_DATA_W'(r_grid_size) : '0;

endmodule

/* hdl/wrst_checker.sv */
`include "weighted_rectangle_sum_tables_unit_defines.svh"

module wrst_checker
    import wrst_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data,
    input logic      o_pready
);

    `WRST_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "stalled result changed or dropped")
    `WRST_ASSERT_IMPL(a_bad_is_zero, i_clk, i_rst_n, o_out_valid && o_out_data.bad_query, o_out_data.weighted_sum == '0, "rejected query carries a nonzero sum")
    `WRST_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "input ready right after a transaction")
    `WRST_ASSERT_IMPL(a_pready, i_clk, i_rst_n, 1'b1, o_pready, "configuration port not ready")

endmodule

bind weighted_rectangle_sum_tables_unit wrst_checker u_wrst_checker (.*);

/* verif/tb_weighted_rectangle_sum_tables_unit.sv */
module tb_weighted_rectangle_sum_tables_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import wrst_pkg::*;

    localparam int unsigned SIDE          = 256;
    localparam int unsigned CELLS         = SIDE * SIDE;
    localparam int unsigned ITEMS         = 1200;
    localparam int unsigned IDLE_PCT      = 26;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned LIMIT_CYCLES  = 3_000_000;
    localparam int unsigned HOLD_PHASE    = 2;
    localparam int unsigned BIG_PHASE     = 3;
    localparam int unsigned PAUSE_PHASE   = 4;
    localparam int unsigned BIG_SIDE      = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = CFG_IDX_GRID_SIZE + 1'b1;
    localparam t_out_item REJECTED = '{weighted_sum: '0, bad_query: 1'b1};

    typedef enum logic [1:0] {
        STEP_PREDICT,
        STEP_PINNED,
        STEP_WRITE
    } t_step_kind;

    typedef struct {
        t_step_kind            kind;
        t_in_item              item;
        t_out_item             result;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [APB_DATA_W-1:0] reg_value;
    } t_step;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_data;
    logic                  i_psel      = 1'b0;
    logic                  i_penable   = 1'b0;
    logic                  i_pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0] i_paddr     = '0;
    logic [APB_DATA_W-1:0] i_pwdata    = '0;
    logic [APB_DATA_W-1:0] o_prdata;
    logic                  o_pready;

    logic        pinned_valid  = 1'b0;
    t_out_item   pinned_result = '0;
    logic        calm          = 1'b0;
    logic        hold_request  = 1'b0;
    int unsigned cycle_count   = 0;
    int unsigned error_count   = 0;

    logic [63:0]       sat_tab [3][CELLS];
    logic [63:0]       line_acc [3];
    int unsigned       fill_row;
    int unsigned       fill_col;
    logic [GRID_W-1:0] side_reg;
    t_out_item         awaited_sums [$];
    t_step             directed [$];

    weighted_rectangle_sum_tables_unit i_dut (.*);

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic int unsigned clamp_side(input logic [GRID_W-1:0] value);
        if (value == '0) return 1;
        if (value > SIDE) return SIDE;
        return 32'(value);
    endfunction

    function automatic void await_result(input t_out_item res);
        awaited_sums.insert(awaited_sums.size(), res);
    endfunction

    function automatic void add_step(input t_step s);
        directed.insert(directed.size(), s);
    endfunction

    function automatic logic [63:0] rect_sum(input int k, input int unsigned r1, c1, r2, c2);
        logic [63:0] s;
        s = sat_tab[k][r2 * SIDE + c2];
        if (r1 > 0) s -= sat_tab[k][(r1 - 1) * SIDE + c2];
        if (c1 > 0) s -= sat_tab[k][r2 * SIDE + c1 - 1];
        if (r1 > 0 && c1 > 0) s += sat_tab[k][(r1 - 1) * SIDE + c1 - 1];
        return s;
    endfunction

    task automatic restart_fill();
        fill_row = 0;
        fill_col = 0;
        line_acc = '{default: '0};
    endtask

    task automatic apply_item(input t_in_item item, input logic pinned,
                              input t_out_item pinned_res);
        int unsigned n, r, c, a, r1, c1, r2, c2;
        logic [63:0] v;
        logic [63:0] s [3];
        logic [63:0] w;
        logic [63:0] b;
        logic [63:0] total;
        t_out_item res;
        n = clamp_side(side_reg);
        if (item.action == ACT_LOAD) begin
            if (fill_row < n) begin
                r = fill_row;
                c = fill_col;
                a = r * SIDE + c;
                v = 64'(item.cell_value);
                line_acc[0] += v;
                line_acc[1] += v * r;
                line_acc[2] += v * c;
                for (int k = 0; k < 3; k++) begin
                    sat_tab[k][a] = (r > 0 ? sat_tab[k][a - SIDE] : 64'd0) + line_acc[k];
                end
                if (c + 1 >= n) begin
                    fill_row = r + 1;
                    fill_col = 0;
                    line_acc = '{default: '0};
                end else begin
                    fill_col = c + 1;
                end
            end
        end else begin
            r1 = item.top_row;
            c1 = item.left_col;
            r2 = item.bottom_row;
            c2 = item.right_col;
            if (fill_row < n || r1 > r2 || c1 > c2 || r2 >= n || c2 >= n) begin
                res = REJECTED;
            end else begin
                for (int k = 0; k < 3; k++) begin
                    s[k] = rect_sum(k, r1, c1, r2, c2);
                end
                w = 64'(c2 - c1 + 1);
                b = w * r1 + c1 - 64'd1;
                total = s[2] + s[1] * w - b * s[0];
                res = '{weighted_sum: total[SUM_W-1:0], bad_query: 1'b0};
            end
            await_result(pinned ? pinned_res : res);
        end
    endtask

    function void report_error(input string what, input logic [63:0] want, got);
        error_count++;
        if (error_count <= 10) begin
            $display("error at cycle %0d: %s expected %0h got %0h", cycle_count, what, want, got);
        end
    endfunction

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (awaited_sums.size() == 0) begin
            report_error("result with none awaited, weighted_sum", '0, 64'(got.weighted_sum));
        end else begin
            want = awaited_sums.pop_front();
            if (got.weighted_sum !== want.weighted_sum) begin
                report_error("weighted_sum", 64'(want.weighted_sum), 64'(got.weighted_sum));
            end
            if (got.bad_query !== want.bad_query) begin
                report_error("bad_query", 64'(want.bad_query), 64'(got.bad_query));
            end
        end
    endtask

    // Every transaction on either channel and every register write is seen here.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            side_reg = GRID_SIZE_RESET;
            restart_fill();
        end else begin
            if (i_psel && i_penable && i_pwrite && o_pready) begin
                if (i_paddr[APB_ADDR_W-1:2] == CFG_IDX_GRID_SIZE) begin
                    side_reg = i_pwdata[GRID_W-1:0];
                    restart_fill();
                end
            end
            if (i_in_valid && o_in_ready) apply_item(i_in_data, pinned_valid, pinned_result);
            if (o_out_valid && i_out_ready) check_result(o_out_data);
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (calm) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("weighted_rectangle_sum_tables_unit: mismatch");
        $finish;
    end

    function automatic t_in_item load_item(input logic [VALUE_IN_W-1:0] value);
        return '{action: ACT_LOAD, cell_value: value, top_row: 8'($urandom),
                 left_col: 8'($urandom), bottom_row: 8'($urandom), right_col: 8'($urandom)};
    endfunction

    function automatic t_in_item query_item(input int unsigned r1, c1, r2, c2);
        return '{action: ACT_QUERY, cell_value: 16'($urandom), top_row: 8'(r1),
                 left_col: 8'(c1), bottom_row: 8'(r2), right_col: 8'(c2)};
    endfunction

    function automatic t_in_item random_load();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 5) return load_item('0);
        if (roll < 10) return load_item('1);
        return load_item(16'($urandom));
    endfunction

    function automatic t_in_item random_query(input int unsigned n, input logic well_formed);
        int unsigned r1, c1;
        if (!well_formed) begin
            return query_item($urandom_range(0, 255), $urandom_range(0, 255),
                              $urandom_range(0, 255), $urandom_range(0, 255));
        end
        r1 = $urandom_range(0, n - 1);
        c1 = $urandom_range(0, n - 1);
        return query_item(r1, c1, $urandom_range(r1, n - 1), $urandom_range(c1, n - 1));
    endfunction

    function automatic t_step step_item(input t_in_item item);
        return '{STEP_PREDICT, item, '0, '0, '0};
    endfunction

    function automatic t_step step_pinned(input t_in_item item, input t_out_item result);
        return '{STEP_PINNED, item, result, '0, '0};
    endfunction

    function automatic t_step step_write(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [APB_DATA_W-1:0] value);
        return '{STEP_WRITE, '0, '0, idx, value};
    endfunction

    task automatic offer(input t_in_item item, input logic pinned, input t_out_item result);
        if (!calm) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid    <= 1'b1;
        i_in_data     <= item;
        pinned_valid  <= pinned;
        pinned_result <= result;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic settle(input int unsigned extra);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (awaited_sums.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] value);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= {idx, 2'b00};
        i_pwdata  <= value;
        @(posedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
    endtask

    initial begin
        logic [VALUE_IN_W-1:0] grid3 [9];
        logic [GRID_W-1:0] size;
        logic abandon;
        int unsigned n, cells, queries, roll, random_items, phase;

        grid3 = '{16'hFFFF, 16'd0, 16'd3, 16'd4, 16'hFFFF, 16'd6, 16'd7, 16'd8, 16'hFFFF};
        add_step(step_pinned(query_item(0, 0, 0, 0), REJECTED));
        add_step(step_write(CFG_IDX_GRID_SIZE, '0));
        add_step(step_pinned(query_item(0, 0, 0, 0), REJECTED));
        add_step(step_item(load_item('1)));
        add_step(step_pinned(query_item(0, 0, 0, 0),
                             '{weighted_sum: 48'hFFFF, bad_query: 1'b0}));
        add_step(step_item(load_item(16'd7)));
        add_step(step_pinned(query_item(0, 0, 0, 0),
                             '{weighted_sum: 48'hFFFF, bad_query: 1'b0}));
        add_step(step_pinned(query_item(0, 0, 0, 1), REJECTED));
        add_step(step_write(CFG_IDX_GRID_SIZE, 32'd3));
        foreach (grid3[i]) add_step(step_item(load_item(grid3[i])));
        add_step(step_item(query_item(0, 0, 2, 2)));
        add_step(step_item(query_item(1, 1, 2, 2)));
        add_step(step_item(query_item(0, 2, 2, 2)));
        add_step(step_write(CFG_IDX_UNUSED, '1));
        add_step(step_item(query_item(2, 0, 2, 0)));
        add_step(step_pinned(query_item(2, 0, 1, 0), REJECTED));
        add_step(step_pinned(query_item(0, 2, 0, 1), REJECTED));
        add_step(step_pinned(query_item(0, 0, 3, 0), REJECTED));
        add_step(step_pinned(query_item(255, 255, 255, 255), REJECTED));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) begin
            if (directed[i].kind == STEP_WRITE) begin
                settle(SETTLE_CYCLES);
                reg_write(directed[i].reg_idx, directed[i].reg_value);
            end else begin
                offer(directed[i].item, directed[i].kind == STEP_PINNED, directed[i].result);
            end
        end

        random_items = 0;
        phase = 0;
        while (random_items < ITEMS) begin
            phase++;
            roll = $urandom_range(0, 99);
            if (phase == BIG_PHASE) size = GRID_W'(BIG_SIDE);
            else if (roll < 10) size = '0;
            else if (roll < 80) size = GRID_W'($urandom_range(1, 6));
            else size = GRID_W'($urandom_range(7, 16));
            n = clamp_side(size);
            settle(SETTLE_CYCLES);
            reg_write(CFG_IDX_GRID_SIZE, APB_DATA_W'(size));
            abandon = (phase != BIG_PHASE) && (phase != HOLD_PHASE)
                      && ($urandom_range(0, 99) < 10);
            cells = abandon ? $urandom_range(0, n * n - 1) : n * n;
            calm = (phase == BIG_PHASE);
            for (int i = 0; i < cells; i++) begin
                if (!calm && $urandom_range(0, 99) < 5) begin
                    offer(random_query(n, 1'b1), 1'b0, '0);
                    random_items++;
                end
                offer(random_load(), 1'b0, '0);
                random_items++;
            end
            calm = 1'b0;
            if (abandon) begin
                queries = $urandom_range(1, 3);
            end else begin
                repeat ($urandom_range(0, 2)) offer(random_load(), 1'b0, '0);
                if (phase == BIG_PHASE) queries = 40;
                else if (phase == HOLD_PHASE) queries = 24;
                else queries = $urandom_range(4, 12);
            end
            if (phase == BIG_PHASE) begin
                offer(query_item(0, 0, n - 1, n - 1), 1'b0, '0);
                offer(query_item(n - 1, n - 1, n - 1, n - 1), 1'b0, '0);
            end
            for (int q = 0; q < queries; q++) begin
                if (phase == HOLD_PHASE && q == 0) hold_request = 1'b1;
                if (phase == PAUSE_PHASE && q == queries / 2) settle(0);
                offer(random_query(n, $urandom_range(0, 99) < 85), 1'b0, '0);
                random_items++;
            end
        end

        settle(SETTLE_CYCLES);
        if (error_count == 0 && awaited_sums.size() == 0) begin
            $display("weighted_rectangle_sum_tables_unit: match");
        end else begin
            $display("weighted_rectangle_sum_tables_unit: mismatch");
        end
        $finish;
    end
endmodule
